// ----- hdl/assert_macros.svh -----
// assertion macros for the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/lnv_pkg.sv -----
// types and constants of the layer normalization block
// no dependencies
package lnv_pkg;

   localparam int SAMPLE_W = 16;
   localparam int VLEN_W   = 7;
   localparam int FLOOR_W  = 10;
   localparam int SUM_W    = 22;
   localparam int D_W      = 24;
   localparam int AD_W     = 23;
   localparam int Q_W      = 52;
   localparam int MA_W     = 33;
   localparam int MB_W     = 25;
   localparam int MP_W     = MA_W + MB_W;
   localparam int PROD_SH  = 22;
   localparam int R_W      = 74;
   localparam int QUO_W    = 29;
   localparam int DV_W     = Q_W + QUO_W - 1;
   localparam int K_W      = 15;
   localparam int CNT5_W   = 5;

   localparam logic [0:0] REG_VECTOR_LENGTH  = 1'b0;
   localparam logic [0:0] REG_VARIANCE_FLOOR = 1'b1;

   localparam logic [VLEN_W-1:0]  VLEN_RESET  = 7'd16;
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = 10'd10;

   typedef enum logic [3:0] {
      S_IDLE, S_F0, S_F1, S_F2, S_F3,
      S_VD, S_VAD, S_VSQ, S_VACC,
      S_OD, S_OAD, S_OM1, S_OM2, S_ODIV, S_OWAIT
   } state_type;

   typedef enum logic [1:0] {RT_IDLE, RT_DIV, RT_SQRT} root_state_type;

   typedef struct packed {
      logic             start;
      logic [R_W-1:0]   dividend;
      logic [Q_W-1:0]   divisor;
   } root_req_type;

   typedef struct packed {
      logic             done;
      logic [K_W-1:0]   k;
   } root_rsp_type;

endpackage

// ----- hdl/layer_norm_vector_top.sv -----
// Layer normalization over a vector of signed Q5.10 samples, no gain or bias.
// Samples load one per cycle while busy is low; the sample that completes the
// vector raises busy. The block then works out the epsilon term and runs the
// variance pass through the shared multiplier, then computes each result with
// the 29-step divider and 15-step square root of the shared root unit. Results
// leave one per strobe with last on the final one; the receiver cannot stall,
// and busy drops the cycle after the last result. No clearing pass is needed.
// depends on lnv_pkg, lnv_mul, lnv_root
module layer_norm_vector_top #(
   parameter int MAX_LENGTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [lnv_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 rsp_strobe,
   output logic signed [lnv_pkg::SAMPLE_W-1:0]  rsp_normalized,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import lnv_pkg::*;

   localparam int CNT_W = $clog2(MAX_LENGTH + 1);
   localparam int IDX_W = $clog2(MAX_LENGTH);

   // configuration registers
   logic [VLEN_W-1:0]  vlen_ff;
   logic [FLOOR_W-1:0] floor_ff;
   logic               csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff  <= VLEN_RESET;
         floor_ff <= FLOOR_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_VECTOR_LENGTH) begin
            vlen_ff <= pwdata[VLEN_W-1:0];
         end else begin
            floor_ff <= pwdata[FLOOR_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_VARIANCE_FLOOR) ? {{(32-FLOOR_W){1'b0}}, floor_ff}
                                                    : {{(32-VLEN_W){1'b0}}, vlen_ff};

   // sequencer and datapath registers
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [Q_W-1:0]        q_ff, q_in;
   logic signed [D_W-1:0] d_ff, d_in;
   logic                  last_ff, last_in;
   logic                  strobe_ff, strobe_in;
   logic signed [SAMPLE_W-1:0] norm_ff, norm_in;
   logic                  rlast_ff, rlast_in;

   logic signed [SAMPLE_W-1:0] mem [MAX_LENGTH];
   logic signed [SAMPLE_W-1:0] rdata_ff;
   logic                  mem_we;

   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [MP_W-1:0] prod;
   root_req_type          root_req;
   root_rsp_type          root_rsp;

   logic [VLEN_W-1:0]     len_clip;
   logic [CNT_W-1:0]      eff_len;
   logic [CNT_W-1:0]      fill_next;
   logic [AD_W-1:0]       ad;
   logic [SAMPLE_W-1:0]   kmag;
   logic                  accept;

   // sample store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fill_ff[IDX_W-1:0]] <= req_sample;
      end
      rdata_ff <= mem[idx_ff];
   end

   lnv_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p_ff  (prod)
   );

   lnv_root u_root (
      .clock (clock),
      .reset (reset),
      .req   (root_req),
      .rsp   (root_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         sum_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         sum_ff    <= sum_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      idx_ff   <= idx_in;
      q_ff     <= q_in;
      d_ff     <= d_in;
      last_ff  <= last_in;
      norm_ff  <= norm_in;
      rlast_ff <= rlast_in;
   end

   // effective vector length
   assign len_clip  = (vlen_ff > VLEN_W'(MAX_LENGTH)) ? VLEN_W'(MAX_LENGTH) : vlen_ff;
   assign eff_len   = (vlen_ff == '0) ? CNT_W'(1) : CNT_W'(len_clip);
   assign fill_next = fill_ff + 1'b1;
   assign accept    = start & ~busy;
   assign mem_we    = accept;
   assign ad        = d_ff[D_W-1] ? AD_W'(-d_ff) : AD_W'(d_ff);
   assign kmag      = {1'b0, root_rsp.k};

   // next state and operand selection
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      n_in      = n_ff;
      idx_in    = idx_ff;
      q_in      = q_ff;
      d_in      = d_ff;
      last_in   = last_ff;
      strobe_in = 1'b0;
      norm_in   = norm_ff;
      rlast_in  = rlast_ff;
      mul_a     = {{(MA_W-SAMPLE_W){rdata_ff[SAMPLE_W-1]}}, rdata_ff};
      mul_b     = {{(MB_W-CNT_W){1'b0}}, n_ff};
      root_req.start    = 1'b0;
      root_req.dividend = {prod[R_W-PROD_SH-1:0], {PROD_SH{1'b0}}};
      root_req.divisor  = q_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sum_in = sum_ff + SUM_W'(req_sample);
               if (fill_next < eff_len) begin
                  fill_in = fill_next;
               end else begin
                  n_in     = fill_next;
                  idx_in   = '0;
                  state_in = S_F0;
               end
            end
         end
         // epsilon term: floor * n^3
         S_F0: begin
            mul_a    = {{(MA_W-FLOOR_W){1'b0}}, floor_ff};
            state_in = S_F1;
         end
         S_F1: begin
            mul_a    = prod[MA_W-1:0];
            state_in = S_F2;
         end
         S_F2: begin
            mul_a    = prod[MA_W-1:0];
            state_in = S_F3;
         end
         S_F3: begin
            q_in     = prod[Q_W-1:0];
            state_in = S_VD;
         end
         // variance pass: q += (n*x - s)^2
         S_VD: begin
            state_in = S_VAD;
         end
         S_VAD: begin
            d_in     = prod[D_W-1:0] - D_W'(sum_ff);
            last_in  = (idx_ff == IDX_W'(n_ff - 1'b1));
            idx_in   = (idx_ff == IDX_W'(n_ff - 1'b1)) ? '0 : idx_ff + 1'b1;
            state_in = S_VSQ;
         end
         S_VSQ: begin
            mul_a    = {{(MA_W-AD_W){1'b0}}, ad};
            mul_b    = {{(MB_W-AD_W){1'b0}}, ad};
            state_in = S_VACC;
         end
         S_VACC: begin
            q_in     = q_ff + prod[Q_W-1:0];
            state_in = last_ff ? S_OD : S_VD;
         end
         // output pass: k from (ad^2 * n * 2^22) / q
         S_OD: begin
            state_in = S_OAD;
         end
         S_OAD: begin
            d_in     = prod[D_W-1:0] - D_W'(sum_ff);
            last_in  = (idx_ff == IDX_W'(n_ff - 1'b1));
            idx_in   = idx_ff + 1'b1;
            state_in = S_OM1;
         end
         S_OM1: begin
            mul_a    = {{(MA_W-AD_W){1'b0}}, ad};
            state_in = S_OM2;
         end
         S_OM2: begin
            mul_a    = prod[MA_W-1:0];
            mul_b    = {{(MB_W-AD_W){1'b0}}, ad};
            state_in = S_ODIV;
         end
         S_ODIV: begin
            root_req.start = (ad != '0);
            state_in       = S_OWAIT;
         end
         S_OWAIT: begin
            if (ad == '0 || root_rsp.done) begin
               strobe_in = 1'b1;
               rlast_in  = last_ff;
               if (ad == '0) begin
                  norm_in = '0;
               end else begin
                  norm_in = d_ff[D_W-1] ? -kmag : kmag;
               end
               if (last_ff) begin
                  fill_in  = '0;
                  sum_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_OD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy           = (state_ff != S_IDLE) | strobe_ff;
   assign rsp_strobe     = strobe_ff;
   assign rsp_normalized = norm_ff;
   assign rsp_last       = rlast_ff;

endmodule

// ----- hdl/lnv_mul.sv -----
// shared signed multiplier with registered product
// depends on lnv_pkg
module lnv_mul (
   input  logic                            clock,
   input  logic signed [lnv_pkg::MA_W-1:0] a,
   input  logic signed [lnv_pkg::MB_W-1:0] b,
   output logic signed [lnv_pkg::MP_W-1:0] p_ff
);
   import lnv_pkg::*;

   logic signed [MP_W-1:0] p_in;

   // one product per cycle
   assign p_in = a * b;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

// ----- hdl/lnv_root.sv -----
// iterative unit: restoring divide, then bit-wise integer square root
// depends on lnv_pkg; returns k = floor((isqrt(dividend/divisor)+1)/2)
module lnv_root (
   input  logic                  clock,
   input  logic                  reset,
   input  lnv_pkg::root_req_type req,
   output lnv_pkg::root_rsp_type rsp
);
   import lnv_pkg::*;

   root_state_type     state_ff, state_in;
   logic [R_W-1:0]     rem_ff, rem_in;
   logic [DV_W-1:0]    dv_ff, dv_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [QUO_W-1:0]   res_ff, res_in;
   logic [QUO_W-1:0]   bit_ff, bit_in;
   logic [CNT5_W-1:0]  cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [QUO_W-1:0]   trial;
   logic [QUO_W-1:0]   res_next;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RT_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      k_ff   <= k_in;
   end

   // one divide or root step per cycle
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dv_in    = dv_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      k_in     = k_ff;
      trial    = res_ff + bit_ff;
      res_next = res_ff >> 1;
      case (state_ff)
         RT_IDLE: begin
            if (req.start) begin
               rem_in   = req.dividend;
               dv_in    = {req.divisor, {(QUO_W-1){1'b0}}};
               quo_in   = '0;
               cnt_in   = CNT5_W'(QUO_W - 1);
               state_in = RT_DIV;
            end
         end
         RT_DIV: begin
            if ({{(DV_W-R_W){1'b0}}, rem_ff} >= dv_ff) begin
               rem_in = rem_ff - dv_ff[R_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            dv_in  = dv_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               res_in   = '0;
               bit_in   = {1'b1, {(QUO_W-1){1'b0}}};
               state_in = RT_SQRT;
            end
         end
         RT_SQRT: begin
            if (quo_ff >= trial) begin
               quo_in   = quo_ff - trial;
               res_next = (res_ff >> 1) + bit_ff;
            end
            res_in = res_next;
            bit_in = bit_ff >> 2;
            if (bit_ff == QUO_W'(1)) begin
               k_in     = K_W'((res_next + 1'b1) >> 1);
               done_in  = 1'b1;
               state_in = RT_IDLE;
            end
         end
         default: state_in = RT_IDLE;
      endcase
   end

   assign rsp.done = done_ff;
   assign rsp.k    = k_ff;

endmodule

// ----- hdl/lnv_checker.sv -----
// port-level checks of the layer normalization block, with its bind
// depends on assert_macros.svh and layer_norm_vector_top
`include "assert_macros.svh"

module lnv_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last
);

   // results come out only while the block is busy
   `ASSERT_CLK(a_strobe_busy, clock, reset, rsp_strobe |-> busy, "result beat while not busy")
   // result beats are never adjacent
   `ASSERT_CLK(a_strobe_gap, clock, reset, rsp_strobe |=> !rsp_strobe, "back to back result beats")
   // the final beat frees the input side next cycle
   `ASSERT_CLK(a_last_frees, clock, reset, rsp_strobe && rsp_last |=> !busy, "busy after last beat")
   // reset leaves the block idle and quiet
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_strobe, "not idle after reset")

endmodule

bind layer_norm_vector_top lnv_checker u_lnv_checker (.*);

// ----- test/testbench.sv -----
// self-checking testbench for layer_norm_vector_top: directed and random vectors
// predicts every normalized result with exact integer arithmetic
// depends on lnv_pkg and the layer_norm_vector_top rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lnv_pkg::*;

   localparam int MAX_LEN = 64;

   typedef struct {
      logic signed [SAMPLE_W-1:0] normalized;
      logic                       last;
   } norm_beat_type;

   // scoreboard: shadow state of the block and the queue of expected beats
   class norm_scoreboard;
      logic [VLEN_W-1:0]          vlen;
      logic [FLOOR_W-1:0]         eps;
      logic signed [SAMPLE_W-1:0] store [MAX_LEN];
      int                         fill;
      longint                     sum;
      norm_beat_type              expected_beats [$];
      int                         mismatches;

      function new();
         vlen = VLEN_RESET;
         eps = FLOOR_RESET;
         fill = 0;
         sum = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [0:0] idx, logic [31:0] value);
         if (idx == REG_VECTOR_LENGTH) vlen = value[VLEN_W-1:0];
         else eps = value[FLOOR_W-1:0];
      endfunction

      // round(ad * 2^10 * sqrt(n / q)) by search on (2k-1)^2 * q <= ad^2 * n * 2^22
      function longint scaled_mag(longint ad, longint q, int n);
         logic [127:0] rhs;
         logic [127:0] lhs;
         longint lo;
         longint hi;
         longint mid;
         logic [63:0] t;
         rhs = (128'(ad) * 128'(ad) * 128'(n)) << 22;
         lo = 0;
         hi = 32768;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 64'(2 * mid - 1);
            lhs = 128'(t * t) * 128'(q);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] x);
         int            len;
         int            n;
         longint        q;
         longint        d;
         longint        ad;
         longint        m;
         longint        y;
         norm_beat_type b;
         len = vlen;
         if (len == 0) len = 1;
         if (len > MAX_LEN) len = MAX_LEN;
         store[fill % MAX_LEN] = x;
         sum += x;
         if (fill + 1 < len) begin
            fill++;
            return;
         end
         n = fill + 1;
         q = longint'(eps) * n * n * n;
         for (int i = 0; i < n; i++) begin
            d = longint'(n) * store[i] - sum;
            ad = d < 0 ? -d : d;
            q += ad * ad;
         end
         for (int i = 0; i < n; i++) begin
            d = longint'(n) * store[i] - sum;
            ad = d < 0 ? -d : d;
            y = 0;
            if (ad != 0 && q != 0) begin
               m = scaled_mag(ad, q, n);
               if (d < 0) y = -m;
               else y = m > 32767 ? 32767 : m;
            end
            b.normalized = y[SAMPLE_W-1:0];
            b.last = (i + 1 == n);
            expected_beats.push_back(b);
         end
         fill = 0;
         sum = 0;
      endfunction

      function void check_result(logic signed [SAMPLE_W-1:0] norm, logic last);
         norm_beat_type b;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: normalized %0d last %0b",
                                           norm, last);
            return;
         end
         b = expected_beats.pop_front();
         if (b.normalized !== norm || b.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("beat mismatch: expected %0d/%0b, got %0d/%0b",
                        b.normalized, b.last, norm, last);
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       rsp_strobe;
   logic signed [SAMPLE_W-1:0] rsp_normalized;
   logic                       rsp_last;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [2:0]                 paddr;
   logic [31:0]                pwdata;
   logic [31:0]                prdata;
   logic                       pready;

   norm_scoreboard sb = new();
   int  sent = 0;
   bit  quiet = 0;

   layer_norm_vector_top dut (.*);

   // clock
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_normalized, rsp_last);
   end

   // write one register through the apb port
   task automatic csr_write(logic [0:0] idx, logic [31:0] value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      sb.write_reg(idx, value);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      @(posedge clock);
   endtask

   // sender gap: start low for a random burst
   task automatic sender_gap();
      int n;
      n = $urandom_range(1, 13);
      start <= 0;
      repeat (n) @(posedge clock);
   endtask

   // send one sample beat, waiting out busy
   task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
      if (!quiet && $urandom_range(0, 5) == 0) sender_gap();
      start <= 1;
      req_sample <= x;
      do @(posedge clock); while (busy);
      sb.note_sample(x);
      sent++;
   endtask

   // drain: stop sending and wait until every beat has come and the block is free
   task automatic drain();
      start <= 0;
      do @(posedge clock); while (sb.expected_beats.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(int len, int eps);
      drain();
      csr_write(REG_VECTOR_LENGTH, len);
      csr_write(REG_VARIANCE_FLOOR, eps);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_sample(int mode, int base);
      if (mode == 0) return SAMPLE_W'($urandom);
      return SAMPLE_W'(base + int'($urandom_range(0, 64)) - 32);
   endfunction

   // stimulus
   initial begin
      int len;
      int eps;
      int mode;
      int base;
      int vecs;
      reset = 1;
      start = 0;
      req_sample = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings, one full vector
      for (int i = 0; i < 16; i++) send_sample(i[0] ? 16'sh7fff : 16'sh8000);
      // one-sample vector gives zero
      set_config(1, 1023);
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      // length zero acts as one
      set_config(0, 0);
      send_sample(16'sh1234);
      // equal samples with no floor: zero variance
      set_config(3, 0);
      repeat (3) send_sample(16'sh0400);
      // extreme pair
      set_config(2, 1023);
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      // length lowered mid-vector ends it with the next sample
      set_config(8, 10);
      repeat (5) send_sample(SAMPLE_W'($urandom));
      set_config(3, 10);
      send_sample(16'sh0001);
      // oversized length acts as the maximum
      set_config(127, 0);
      for (int i = 0; i < 64; i++) send_sample(rand_sample(1, -20000));

      // random phases
      while (sent < 470) begin
         case ($urandom_range(0, 9))
            0: len = 64;
            1: len = $urandom_range(0, 1);
            2: len = $urandom_range(65, 127);
            default: len = $urandom_range(2, 12);
         endcase
         case ($urandom_range(0, 3))
            0: eps = 0;
            1: eps = 1023;
            default: eps = $urandom_range(0, 1023);
         endcase
         if (sent > 390) quiet = 1;
         set_config(len, eps);
         vecs = (len == 0 || len > 12) ? 1 : $urandom_range(1, 4);
         if (len > MAX_LEN) len = MAX_LEN;
         if (len == 0) len = 1;
         for (int v = 0; v < vecs; v++) begin
            mode = $urandom_range(0, 2);
            base = $urandom_range(0, 65535) - 32768;
            for (int i = 0; i < len; i++) send_sample(rand_sample(mode, base));
         end
         // sometimes send extra samples, which may leave a partial vector for the next setting
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, len)) send_sample(SAMPLE_W'($urandom));
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
         $display("layer_norm_vector_top: match");
      else
         $display("layer_norm_vector_top: mismatch");
      $finish;
   end

   // run limit
   initial begin
      #4ms;
      $display("layer_norm_vector_top: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/lnv_pkg.sv
hdl/lnv_mul.sv
hdl/lnv_root.sv
hdl/layer_norm_vector_top.sv
hdl/lnv_checker.sv
test/testbench.sv
